// ===== hw/rtl/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Shared widths, request and control codes, and the sequencer microprogram
// for the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int MAX_DIM   = 8;
    localparam int DIM_W     = 4;
    localparam int ROW_W     = 3;
    localparam int REQ_W     = 2;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SUM_W     = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = DIM_W;
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE_A = 2'd0,
        REQ_WRITE_B = 2'd1,
        REQ_WRITE_C = 2'd2,
        REQ_START   = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_ADDR = 3'd1,
        ST_LOAD = 3'd2,
        ST_MUL  = 3'd3,
        ST_ACC  = 3'd4,
        ST_EMIT = 3'd5,
        ST_NEXT = 3'd6,
        ST_LOOP = 3'd7
    } t_step;

    typedef enum logic [2:0] {
        J_NEVER   = 3'd0,
        J_ALWAYS  = 3'd1,
        J_NOSTART = 3'd2,
        J_KZERO   = 3'd3,
        J_KMORE   = 3'd4,
        J_OUTBUSY = 3'd5,
        J_LAST    = 3'd6
    } t_cond;

    typedef struct packed {
        logic  ready;
        logic  clr;
        logic  ld_acc;
        logic  mul;
        logic  inc_k;
        logic  add;
        logic  emit;
        logic  advance;
        t_cond cond;
        t_step target;
    } t_uop;

    typedef struct packed {
        logic                     wr_en;
        t_req                     wr_sel;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [ELEM_W-1:0] wr_data;
        logic [ADDR_W-1:0]        rd_a;
        logic [ADDR_W-1:0]        rd_b;
        logic [ADDR_W-1:0]        rd_c;
        logic                     ld_acc;
        logic                     mul;
        logic                     add;
        logic                     emit;
        logic                     last;
        logic [ROW_W-1:0]         row;
        logic [ROW_W-1:0]         col;
    } t_ctl;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [ROW_W-1:0] row,
                                                   input logic [ROW_W-1:0] col);
        mem_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
    endfunction

    function automatic t_uop ucode(input t_step step);
        t_uop u;
        u = '0;
        unique case (step)
            ST_IDLE: begin
                u.ready  = 1'b1;
                u.clr    = 1'b1;
                u.cond   = J_NOSTART;
                u.target = ST_IDLE;
            end
            ST_ADDR: begin
                u.cond   = J_NEVER;
                u.target = ST_IDLE;
            end
            ST_LOAD: begin
                u.ld_acc = 1'b1;
                u.cond   = J_KZERO;
                u.target = ST_EMIT;
            end
            ST_MUL: begin
                u.mul    = 1'b1;
                u.inc_k  = 1'b1;
                u.cond   = J_NEVER;
                u.target = ST_IDLE;
            end
            ST_ACC: begin
                u.add    = 1'b1;
                u.cond   = J_KMORE;
                u.target = ST_MUL;
            end
            ST_EMIT: begin
                u.emit   = 1'b1;
                u.cond   = J_OUTBUSY;
                u.target = ST_EMIT;
            end
            ST_NEXT: begin
                u.advance = 1'b1;
                u.cond    = J_LAST;
                u.target  = ST_IDLE;
            end
            ST_LOOP: begin
                u.cond   = J_ALWAYS;
                u.target = ST_ADDR;
            end
            default: begin
                u.cond   = J_ALWAYS;
                u.target = ST_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

// ===== hw/rtl/mma_req_if.sv =====
// ----------------------------------------------------------------------------
// mma_req_if
// Request channel: element writes and start requests.
// ----------------------------------------------------------------------------
interface mma_req_if import mma_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [ROW_W-1:0]         row_index;
    logic [ROW_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] elem_value;

    modport source (output valid, req_type, row_index, col_index, elem_value,
                    input ready);
    modport sink   (input valid, req_type, row_index, col_index, elem_value,
                    output ready);
endinterface

// ===== hw/rtl/mma_res_if.sv =====
// ----------------------------------------------------------------------------
// mma_res_if
// Result channel: one element of the result matrix per transfer.
// ----------------------------------------------------------------------------
interface mma_res_if import mma_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        out_row;
    logic [ROW_W-1:0]        out_col;
    logic signed [SUM_W-1:0] sum_value;
    logic                    is_last;

    modport source (output valid, out_row, out_col, sum_value, is_last,
                    input ready);
    modport sink   (input valid, out_row, out_col, sum_value, is_last,
                    output ready);
endinterface

// ===== hw/rtl/mma_seq.sv =====
// ----------------------------------------------------------------------------
// mma_seq
// Microcoded sequencer: step counter over the control program, row, column
// and inner counters, request handshake and store write decode.
// ----------------------------------------------------------------------------
module mma_seq import mma_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DIM_W-1:0] i_rows,
    input  logic [DIM_W-1:0] i_inner,
    input  logic [DIM_W-1:0] i_cols,
    input  t_stat            i_stat,
    mma_req_if.sink          i_req,
    output t_ctl             o_ctl
);

    t_step            r_step, n_step;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_k, n_k;

    t_uop uop;
    logic accept;
    logic start_ok;
    logic row_last;
    logic col_last;
    logic take;
    logic in_range;

    assign uop         = ucode(r_step);
    assign i_req.ready = uop.ready;
    assign accept      = i_req.valid && uop.ready;
    assign start_ok    = accept && (t_req'(i_req.req_type) == REQ_START)
                         && (i_rows != '0) && (i_cols != '0);
    assign row_last    = (r_row == i_rows - DIM_W'(1));
    assign col_last    = (r_col == i_cols - DIM_W'(1));
    assign in_range    = ({1'b0, i_req.row_index} < DIM_W'(MAX_DIM))
                         && ({1'b0, i_req.col_index} < DIM_W'(MAX_DIM));

    always_comb begin
        case (uop.cond)
            J_NEVER:   take = 1'b0;
            J_ALWAYS:  take = 1'b1;
            J_NOSTART: take = !start_ok;
            J_KZERO:   take = (i_inner == '0);
            J_KMORE:   take = (r_k != i_inner);
            J_OUTBUSY: take = i_stat.out_busy;
            J_LAST:    take = row_last && col_last;
            default:   take = 1'b1;
        endcase
    end

    always_comb begin
        n_step = take ? uop.target : t_step'(r_step + 3'd1);
        n_row  = r_row;
        n_col  = r_col;
        n_k    = r_k;
        if (uop.clr) begin
            n_row = '0;
            n_col = '0;
            n_k   = '0;
        end
        if (uop.inc_k) begin
            n_k = r_k + DIM_W'(1);
        end
        if (uop.advance) begin
            n_k = '0;
            if (col_last) begin
                n_col = '0;
                n_row = r_row + DIM_W'(1);
            end else begin
                n_col = r_col + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
            r_row  <= '0;
            r_col  <= '0;
            r_k    <= '0;
        end else begin
            r_step <= n_step;
            r_row  <= n_row;
            r_col  <= n_col;
            r_k    <= n_k;
        end
    end

    always_comb begin
        o_ctl.wr_en   = accept && (t_req'(i_req.req_type) != REQ_START) && in_range;
        o_ctl.wr_sel  = t_req'(i_req.req_type);
        o_ctl.wr_addr = mem_addr(i_req.row_index, i_req.col_index);
        o_ctl.wr_data = i_req.elem_value;
        o_ctl.rd_a    = mem_addr(r_row[ROW_W-1:0], r_k[ROW_W-1:0]);
        o_ctl.rd_b    = mem_addr(r_k[ROW_W-1:0], r_col[ROW_W-1:0]);
        o_ctl.rd_c    = mem_addr(r_row[ROW_W-1:0], r_col[ROW_W-1:0]);
        o_ctl.ld_acc  = uop.ld_acc;
        o_ctl.mul     = uop.mul;
        o_ctl.add     = uop.add;
        o_ctl.emit    = uop.emit && !i_stat.out_busy;
        o_ctl.last    = row_last && col_last;
        o_ctl.row     = r_row[ROW_W-1:0];
        o_ctl.col     = r_col[ROW_W-1:0];
    end

endmodule

// ===== hw/rtl/mma_datapath.sv =====
// ----------------------------------------------------------------------------
// mma_datapath
// Element stores for A, B and initial C, multiplier, 40-bit accumulator and
// the result output register.
// ----------------------------------------------------------------------------
module mma_datapath import mma_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ctl     i_ctl,
    output t_stat    o_stat,
    mma_res_if.source o_res
);

    logic signed [ELEM_W-1:0] r_mem_a [MEM_DEPTH];
    logic signed [ELEM_W-1:0] r_mem_b [MEM_DEPTH];
    logic signed [ELEM_W-1:0] r_mem_c [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]     r_cvld;

    logic signed [ELEM_W-1:0] r_a_q;
    logic signed [ELEM_W-1:0] r_b_q;
    logic signed [ELEM_W-1:0] r_c_q;
    logic                     r_cv_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;

    logic                     r_out_valid;
    logic [ROW_W-1:0]         r_out_row;
    logic [ROW_W-1:0]         r_out_col;
    logic signed [SUM_W-1:0]  r_out_sum;
    logic                     r_out_last;

    logic signed [ELEM_W-1:0] c_init;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_sel == REQ_WRITE_A) begin
            r_mem_a[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        r_a_q <= r_mem_a[i_ctl.rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_sel == REQ_WRITE_B) begin
            r_mem_b[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        r_b_q <= r_mem_b[i_ctl.rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_sel == REQ_WRITE_C) begin
            r_mem_c[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        r_c_q  <= r_mem_c[i_ctl.rd_c];
        r_cv_q <= r_cvld[i_ctl.rd_c];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
        end else if (i_ctl.wr_en && i_ctl.wr_sel == REQ_WRITE_C) begin
            r_cvld[i_ctl.wr_addr] <= 1'b1;
        end
    end

    assign c_init = r_cv_q ? r_c_q : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(r_a_q) * PROD_W'(r_b_q);
        end
        if (i_ctl.ld_acc) begin
            r_acc <= {{(SUM_W-ELEM_W){c_init[ELEM_W-1]}}, c_init};
        end else if (i_ctl.add) begin
            r_acc <= r_acc + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_ctl.emit) begin
            r_out_row  <= i_ctl.row;
            r_out_col  <= i_ctl.col;
            r_out_sum  <= r_acc;
            r_out_last <= i_ctl.last;
        end
    end

    assign o_stat.out_busy = r_out_valid && !o_res.ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.out_row   = r_out_row;
    assign o_res.out_col   = r_out_col;
    assign o_res.sum_value = r_out_sum;
    assign o_res.is_last   = r_out_last;

endmodule

// ===== hw/rtl/matrix_multiply_accumulate.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Element writes are accepted only while no walk is running and give no result.
// A start request walks the result in row-major order; each element steps through
// address, load, one multiply and one add per inner step, emit (held while the
// previous result is not yet taken) and next; the walk then returns to idle.
// Reset sets every dimension to 8 and clears initial C; A and B are undefined.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate import mma_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    mma_req_if.sink              i_req,
    mma_res_if.source            o_res
);

    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_inner_dim;
    logic [DIM_W-1:0] r_cols_b;

    logic [DIM_W-1:0] eff_rows;
    logic [DIM_W-1:0] eff_inner;
    logic [DIM_W-1:0] eff_cols;

    t_ctl  ctl;
    t_stat stat;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        sat_dim = (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_RESET;
            r_inner_dim <= DIM_RESET;
            r_cols_b    <= DIM_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_rows  = sat_dim(r_rows_a);
    assign eff_inner = sat_dim(r_inner_dim);
    assign eff_cols  = sat_dim(r_cols_b);

    mma_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rows  (eff_rows),
        .i_inner (eff_inner),
        .i_cols  (eff_cols),
        .i_stat  (stat),
        .i_req   (i_req),
        .o_ctl   (ctl)
    );

    mma_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_idle_pending_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready && o_res.valid |-> o_res.is_last)
        else $error("result pending while idle is not the last element");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && (t_req'(i_req.req_type) == REQ_START)
        && (eff_rows != '0) && (eff_cols != '0) |=> !i_req.ready)
        else $error("start request did not begin the walk");

    a_walk_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && !o_res.is_last |=> !i_req.ready)
        else $error("request taken before the last result was produced");
`endif

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb - matrix multiply-accumulate regression
// Preloads A and B, drives directed element writes and starts at the value
// extremes, then random write bursts closed by starts under many dimension
// settings (zero, saturating and in range). A scoreboard predicts every result
// element of each start and checks each accepted result against the oldest
// prediction, while both channels idle at random and the result side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mma_pkg::*;

    class mma_scoreboard;
        typedef struct packed {
            logic [ROW_W-1:0]        row;
            logic [ROW_W-1:0]        col;
            logic signed [SUM_W-1:0] sum;
            logic                    last;
        } t_elem;

        logic signed [ELEM_W-1:0] mat_a [MEM_DEPTH];
        logic signed [ELEM_W-1:0] mat_b [MEM_DEPTH];
        logic signed [ELEM_W-1:0] mat_c [MEM_DEPTH];
        logic [DIM_W-1:0]         dims [3];
        t_elem                    sums_q [$];
        int                       errors;
        int                       delivered;

        function new();
            foreach (mat_c[i]) begin
                mat_a[i] = '0;
                mat_b[i] = '0;
                mat_c[i] = '0;
            end
            foreach (dims[i]) dims[i] = DIM_RESET;
            errors    = 0;
            delivered = 0;
        endfunction

        function int pending();
            return sums_q.size();
        endfunction

        function void set_dim(t_cfg_idx idx, logic [DIM_W-1:0] value);
            dims[idx] = value;
        endfunction

        function int span(t_cfg_idx idx);
            return (dims[idx] > MAX_DIM) ? MAX_DIM : int'(dims[idx]);
        endfunction

        function void note_request(t_req kind, logic [ROW_W-1:0] row,
                                   logic [ROW_W-1:0] col,
                                   logic signed [ELEM_W-1:0] value);
            int                      nr;
            int                      nk;
            int                      nc;
            int                      slot;
            logic signed [SUM_W-1:0] acc;
            t_elem                   elem;
            slot = int'(row) * MAX_DIM + int'(col);
            case (kind)
                REQ_WRITE_A: mat_a[slot] = value;
                REQ_WRITE_B: mat_b[slot] = value;
                REQ_WRITE_C: mat_c[slot] = value;
                default: begin
                    nr = span(CFG_ROWS_A);
                    nk = span(CFG_INNER_DIM);
                    nc = span(CFG_COLS_B);
                    for (int r = 0; r < nr; r++) begin
                        for (int c = 0; c < nc; c++) begin
                            acc = mat_c[r * MAX_DIM + c];
                            for (int k = 0; k < nk; k++)
                                acc += mat_a[r * MAX_DIM + k] * mat_b[k * MAX_DIM + c];
                            elem.row  = ROW_W'(r);
                            elem.col  = ROW_W'(c);
                            elem.sum  = acc;
                            elem.last = (r == nr - 1) && (c == nc - 1);
                            sums_q.push_back(elem);
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                                   logic signed [SUM_W-1:0] sum, logic last);
            t_elem want;
            delivered++;
            if (sums_q.size() == 0) begin
                errors++;
                $error("unexpected result: out_row %0d out_col %0d sum_value %0d",
                       row, col, sum);
                return;
            end
            want = sums_q.pop_front();
            if (row !== want.row) begin
                errors++;
                $error("out_row: expected %0d, actual %0d", want.row, row);
            end
            if (col !== want.col) begin
                errors++;
                $error("out_col: expected %0d, actual %0d", want.col, col);
            end
            if (sum !== want.sum) begin
                errors++;
                $error("sum_value: expected %0d, actual %0d", want.sum, sum);
            end
            if (last !== want.last) begin
                errors++;
                $error("is_last: expected %0b, actual %0b", want.last, last);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    mma_req_if req_ch ();
    mma_res_if res_ch ();

    matrix_multiply_accumulate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    mma_scoreboard book = new();
    int            sent_count = 0;
    bit            held_off = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            book.check_result(res_ch.out_row, res_ch.out_col, res_ch.sum_value,
                              res_ch.is_last);
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_off && book.delivered >= 24) begin
                held_off = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (500) @(posedge i_clk);
            end else begin
                res_ch.ready <= (book.delivered >= 300 && book.delivered < 700) ||
                                ($urandom_range(99) >= 20);
            end
        end
    end

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic int rand_dim();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    endfunction

    task automatic send_request(input t_req kind, input logic [ROW_W-1:0] row,
                                input logic [ROW_W-1:0] col,
                                input logic signed [ELEM_W-1:0] value);
        int gap;
        gap = 0;
        if ((sent_count < 150 || sent_count >= 260) && $urandom_range(99) < 20)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.row_index  <= row;
        req_ch.col_index  <= col;
        req_ch.elem_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        book.note_request(kind, row, col, value);
        sent_count++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (4 + 2 * MAX_DIM + 12) @(posedge i_clk);
    endtask

    task automatic write_dims(input int rows, input int inner, input int cols);
        t_cfg_idx idx [3];
        int       value [3];
        idx   = '{CFG_ROWS_A, CFG_INNER_DIM, CFG_COLS_B};
        value = '{rows, inner, cols};
        for (int i = 0; i < 3; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= CFG_W'(value[i]);
            @(posedge i_clk);
            book.set_dim(idx[i], CFG_W'(value[i]));
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_bursts(input int bursts);
        int n_writes;
        for (int s = 0; s < bursts; s++) begin
            n_writes = $urandom_range(0, 10);
            for (int i = 0; i < n_writes; i++)
                send_request(t_req'($urandom_range(0, 2)), ROW_W'($urandom),
                             ROW_W'($urandom), rand_elem());
            send_request(REQ_START, ROW_W'($urandom), ROW_W'($urandom), rand_elem());
        end
    endtask

    initial begin
        int plan [7][3];
        plan = '{'{1, 1, 1}, '{0, 3, 4}, '{3, 0, 5}, '{4, 5, 0},
                 '{15, 15, 15}, '{9, 12, 10}, '{8, 1, 8}};

        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = '0;
        req_ch.row_index  = '0;
        req_ch.col_index  = '0;
        req_ch.elem_value = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill A and B so that no start reads an unwritten entry
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++)
                send_request(REQ_WRITE_A, ROW_W'(r), ROW_W'(c),
                             (r == MAX_DIM - 1) ? 16'sh8000 : rand_elem());
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++)
                send_request(REQ_WRITE_B, ROW_W'(r), ROW_W'(c),
                             (c == MAX_DIM - 1) ? 16'sh7fff : rand_elem());

        send_request(REQ_WRITE_C, 3'd0, 3'd0, 16'sh7fff);
        send_request(REQ_WRITE_C, 3'd7, 3'd7, 16'sh8000);
        send_request(REQ_WRITE_C, 3'd0, 3'd7, -16'sd1);
        for (int k = 0; k < MAX_DIM; k++) begin
            send_request(REQ_WRITE_A, 3'd0, ROW_W'(k), 16'sh8000);
            send_request(REQ_WRITE_B, ROW_W'(k), 3'd0, 16'sh8000);
        end
        send_request(REQ_START, 3'd7, 3'd7, 16'sh7fff);
        send_request(REQ_START, 3'd0, 3'd0, 16'sh8000);

        foreach (plan[p]) begin
            drain_results();
            write_dims(plan[p][0], plan[p][1], plan[p][2]);
            run_bursts(4);
        end

        while (sent_count < 410) begin
            drain_results();
            write_dims(rand_dim(), rand_dim(), rand_dim());
            run_bursts(6);
        end

        drain_results();
        if (book.errors == 0 && book.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/mma_pkg.sv
hw/rtl/mma_req_if.sv
hw/rtl/mma_res_if.sv
hw/rtl/mma_seq.sv
hw/rtl/mma_datapath.sv
hw/rtl/matrix_multiply_accumulate.sv
sim/tb.sv
